// File: rtl/core/sha1_message_hash_top_assert.svh
// ----------------------------------------------------------------------------
// SHA-1 message hash assertion macros
// Concurrent checks on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_HASH_TOP_ASSERT_SVH
`define SHA1_MESSAGE_HASH_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SHA1H_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sha1h: same-cycle check failed");

// next-cycle implication
`define SHA1H_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sha1h: next-cycle check failed");

`else

`define SHA1H_ASSERT_IMP(label, ante, cons)

`define SHA1H_ASSERT_NXT(label, ante, cons)

`endif

`endif

// File: rtl/core/sha1h_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 message hash package
// Shared types, constants and round functions.
// ----------------------------------------------------------------------------
package sha1h_pkg;

   localparam int LEN_BITS    = 61;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;
   localparam int NUM_WORDS   = 5;
   localparam int ROUND_W     = 7;

   localparam logic [ROUND_W-1:0] LOAD_ROUNDS = 7'd16;
   localparam logic [ROUND_W-1:0] LAST_ROUND  = 7'd79;
   localparam logic [2:0]         LAST_IDX    = 3'd4;
   localparam logic [5:0]         LEN_POS     = 6'd56;
   localparam logic [3:0]         LAST_WORD   = 4'd15;
   localparam logic [7:0]         PAD_BYTE    = 8'h80;

   typedef logic [31:0] word_type;

   localparam word_type K0 = 32'h5A827999;
   localparam word_type K1 = 32'h6ED9EBA1;
   localparam word_type K2 = 32'h8F1BBCDC;
   localparam word_type K3 = 32'hCA62C1D6;

   localparam word_type H_INIT [NUM_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   typedef struct packed {
      word_type word;
      logic     last;
   } qentry_type;

   typedef enum logic [0:0] {
      FR_BYTES,
      FR_PAD
   } front_state_type;

   typedef enum logic [1:0] {
      BK_ROUND,
      BK_ADD,
      BK_OUT
   } back_state_type;

   function automatic word_type rotl1(word_type x);
      return {x[30:0], x[31]};
   endfunction

   function automatic word_type rotl5(word_type x);
      return {x[26:0], x[31:27]};
   endfunction

   function automatic word_type rotl30(word_type x);
      return {x[1:0], x[31:2]};
   endfunction

   // big-endian byte lane insert; lane 0 clears the rest of the word
   function automatic word_type put_byte(word_type w, logic [1:0] lane, logic [7:0] b);
      word_type r;
      case (lane)
         2'd0:    r = {b, 24'h000000};
         2'd1:    r = {w[31:24], b, 16'h0000};
         2'd2:    r = {w[31:16], b, 8'h00};
         default: r = {w[31:8], b};
      endcase
      return r;
   endfunction

   function automatic word_type round_f(logic [ROUND_W-1:0] t, word_type b, word_type c,
                                        word_type d);
      word_type r;
      if (t < 7'd20) begin
         r = (b & c) | (~b & d);
      end else if (t < 7'd40) begin
         r = b ^ c ^ d;
      end else if (t < 7'd60) begin
         r = (b & c) | (b & d) | (c & d);
      end else begin
         r = b ^ c ^ d;
      end
      return r;
   endfunction

   function automatic word_type round_k(logic [ROUND_W-1:0] t);
      word_type r;
      if (t < 7'd20) begin
         r = K0;
      end else if (t < 7'd40) begin
         r = K1;
      end else if (t < 7'd60) begin
         r = K2;
      end else begin
         r = K3;
      end
      return r;
   endfunction

endpackage

// File: rtl/core/sha1h_front.sv
// ----------------------------------------------------------------------------
// SHA-1 front end
// Packs message bytes into big-endian words and appends padding and length.
// ----------------------------------------------------------------------------
`include "sha1_message_hash_top_assert.svh"

module sha1h_front import sha1h_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_byte_present,
   input  logic       req_message_end,
   output logic       q_push,
   output qentry_type q_data,
   input  logic       q_full
);

   front_state_type     state_ff, state_in;
   logic [5:0]          pos_ff, pos_in, pos_next;
   logic [LEN_BITS-1:0] count_ff, count_in;
   word_type            word_ff, word_in;
   logic                first_ff, first_in;
   logic                extra_ff, extra_in;
   logic                accept;
   logic                len_blk;
   logic [63:0]         len_bits;

   assign req_stall = (state_ff != FR_BYTES) || q_full;
   assign accept    = req_valid && !req_stall;
   assign len_bits  = 64'(count_ff) << 3;
   assign len_blk   = !extra_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_BYTES;
         pos_ff   <= '0;
         count_ff <= '0;
         first_ff <= 1'b0;
         extra_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         first_ff <= first_in;
         extra_ff <= extra_in;
      end
      word_ff <= word_in;
   end

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      word_in  = word_ff;
      first_in = first_ff;
      extra_in = extra_ff;
      pos_next = pos_ff;
      q_push   = 1'b0;
      q_data   = '0;
      unique case (state_ff)
         FR_BYTES: begin
            if (accept) begin
               if (req_byte_present) begin
                  word_in  = put_byte(word_ff, pos_ff[1:0], req_data_byte);
                  pos_next = pos_ff + 6'd1;
                  count_in = count_ff + LEN_BITS'(1);
                  // word complete: hand it to the back end
                  if (pos_ff[1:0] == 2'd3) begin
                     q_push = 1'b1;
                     q_data = '{word: word_in, last: 1'b0};
                  end
               end
               pos_in = pos_next;
               if (req_message_end) begin
                  state_in = FR_PAD;
                  first_in = 1'b1;
                  extra_in = (pos_next >= LEN_POS);
               end
            end
         end
         FR_PAD: begin
            if (!q_full) begin
               q_push = 1'b1;
               if (first_ff) begin
                  q_data = '{word: put_byte(word_ff, pos_ff[1:0], PAD_BYTE), last: 1'b0};
               end else if (len_blk && (pos_ff[5:2] == LAST_WORD - 4'd1)) begin
                  q_data = '{word: len_bits[63:32], last: 1'b0};
               end else if (len_blk && (pos_ff[5:2] == LAST_WORD)) begin
                  q_data = '{word: len_bits[31:0], last: 1'b1};
               end else begin
                  q_data = '{word: '0, last: 1'b0};
               end
               first_in = 1'b0;
               pos_in   = {pos_ff[5:2] + 4'd1, 2'b00};
               if (pos_ff[5:2] == LAST_WORD) begin
                  extra_in = 1'b0;
               end
               // length word sent: ready for the next message
               if (len_blk && (pos_ff[5:2] == LAST_WORD)) begin
                  state_in = FR_BYTES;
                  pos_in   = '0;
                  count_in = '0;
               end
            end
         end
         default: begin
            state_in = FR_BYTES;
         end
      endcase
   end

   `SHA1H_ASSERT_IMP(a_pad_blocks_input, state_ff == FR_PAD, req_stall)

endmodule

// File: rtl/core/sha1h_fifo.sv
// ----------------------------------------------------------------------------
// SHA-1 word queue
// Short FIFO of message words between front and back end.
// ----------------------------------------------------------------------------
`include "sha1_message_hash_top_assert.svh"

module sha1h_fifo import sha1h_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  qentry_type push_data,
   output logic       full,
   input  logic       pop,
   output logic       pop_valid,
   output qentry_type pop_data
);

   qentry_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              do_push, do_pop;

   assign full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         cnt_ff <= cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `SHA1H_ASSERT_IMP(a_no_push_when_full, push, !full)
   `SHA1H_ASSERT_IMP(a_count_in_range, 1'b1, cnt_ff <= QCNT_W'(QUEUE_DEPTH))

endmodule

// File: rtl/core/sha1h_back.sv
// ----------------------------------------------------------------------------
// SHA-1 back end
// One compression round per cycle unless waiting on the queue, chaining update and digest output.
// ----------------------------------------------------------------------------
`include "sha1_message_hash_top_assert.svh"

module sha1h_back import sha1h_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  qentry_type  q_data,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   back_state_type     state_ff, state_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   word_type           chain_ff [NUM_WORDS];
   word_type           chain_in [NUM_WORDS];
   word_type           a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type           a_in, b_in, c_in, d_in, e_in;
   word_type           w_ff [16];
   word_type           w_in [16];
   logic               final_ff, final_in;
   logic [2:0]         out_idx_ff, out_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   word_type           rsp_word_ff, rsp_word_in;
   logic [2:0]         rsp_idx_ff, rsp_idx_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               early, step, out_free;
   word_type           w_sched, w_cur, tmp;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_word_index  = rsp_idx_ff;
   assign rsp_last_word   = rsp_last_ff;

   assign early    = (round_ff < LOAD_ROUNDS);
   assign w_sched  = rotl1(w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]);
   assign w_cur    = early ? q_data.word : w_sched;
   assign tmp      = rotl5(a_ff) + round_f(round_ff, b_ff, c_ff, d_ff) + e_ff
                     + round_k(round_ff) + w_cur;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_ROUND;
         round_ff     <= '0;
         final_ff     <= 1'b0;
         out_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= H_INIT;
         a_ff         <= H_INIT[0];
         b_ff         <= H_INIT[1];
         c_ff         <= H_INIT[2];
         d_ff         <= H_INIT[3];
         e_ff         <= H_INIT[4];
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         final_ff     <= final_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         c_ff         <= c_in;
         d_ff         <= d_in;
         e_ff         <= e_in;
      end
      w_ff        <= w_in;
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      final_in     = final_ff;
      out_idx_in   = out_idx_ff;
      chain_in     = chain_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      w_in         = w_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      step         = 1'b0;
      q_pop        = 1'b0;
      unique case (state_ff)
         BK_ROUND: begin
            // first sixteen rounds wait on words from the queue
            step  = !early || q_valid;
            q_pop = early && q_valid;
            if (step) begin
               for (int i = 0; i < 15; i++) begin
                  w_in[i] = w_ff[i + 1];
               end
               w_in[15] = w_cur;
               e_in = d_ff;
               d_in = c_ff;
               c_in = rotl30(b_ff);
               b_in = a_ff;
               a_in = tmp;
               if (round_ff == LOAD_ROUNDS - 7'd1) begin
                  final_in = q_data.last;
               end
               if (round_ff == LAST_ROUND) begin
                  state_in = BK_ADD;
                  round_in = '0;
               end else begin
                  round_in = round_ff + 7'd1;
               end
            end
         end
         BK_ADD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            chain_in[4] = chain_ff[4] + e_ff;
            a_in        = chain_in[0];
            b_in        = chain_in[1];
            c_in        = chain_in[2];
            d_in        = chain_in[3];
            e_in        = chain_in[4];
            out_idx_in  = '0;
            state_in    = final_ff ? BK_OUT : BK_ROUND;
         end
         BK_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = chain_ff[out_idx_ff];
               rsp_idx_in   = out_idx_ff;
               rsp_last_in  = (out_idx_ff == LAST_IDX);
               if (out_idx_ff == LAST_IDX) begin
                  // digest out: restart chaining for the next message
                  chain_in = H_INIT;
                  a_in     = H_INIT[0];
                  b_in     = H_INIT[1];
                  c_in     = H_INIT[2];
                  d_in     = H_INIT[3];
                  e_in     = H_INIT[4];
                  state_in = BK_ROUND;
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = BK_ROUND;
         end
      endcase
   end

   `SHA1H_ASSERT_IMP(a_no_pop_outside_rounds, state_ff != BK_ROUND, !q_pop)
   `SHA1H_ASSERT_IMP(a_last_word_index, rsp_valid_ff && rsp_last_ff, rsp_idx_ff == LAST_IDX)
   `SHA1H_ASSERT_NXT(a_add_restarts_rounds, state_ff == BK_ADD, round_ff == '0)

endmodule

// File: rtl/core/sha1_message_hash_top.sv
// ----------------------------------------------------------------------------
// SHA-1 message hash top level
// Byte-stream SHA-1 with padding, length append and five-word digest output.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  req_      in         req_valid/stall     data_byte, byte_present, message_end
//  rsp_      out        rsp_valid/stall     digest_word, word_index, last_word
//
// The front end takes one item per cycle unless the queue is full or it is padding, and
// packs bytes into a four-word queue; the back end runs one round per cycle, the first
// sixteen waiting on queue words, 80 rounds plus one chaining add per block. The queue
// lets the front end run only 16 bytes ahead.
// At message end the front end emits up to 18 padding words, one per cycle while the
// queue has room; the back end then finishes up to two blocks, sends five digest words.
// Synchronous reset loads the initial hash values; no clearing pass is needed.
// A stalled result holds the back end only; the front end fills the queue, then stalls.
// ----------------------------------------------------------------------------
module sha1_message_hash_top import sha1h_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_message_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   logic       q_push, q_full, q_pop, q_valid;
   qentry_type q_wdata, q_rdata;

   sha1h_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_message_end  (req_message_end),
      .q_push           (q_push),
      .q_data           (q_wdata),
      .q_full           (q_full)
   );

   sha1h_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_rdata)
   );

   sha1h_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_data          (q_rdata),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

endmodule
